// ===== rtl/tic_pkg.sv =====
package tic_pkg;

  // Field widths fixed by the interface
  localparam int BOUND_W   = 16;
  localparam int COUNT_W   = 16;
  localparam int COEFF_W   = 16;
  localparam int OUT_W     = 48;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 4;

  localparam int STEP_BITS_DEF = 16;

  // Datapath widths (Q.24 sample domain)
  localparam int FRAC      = 24;
  localparam int DIV_W     = BOUND_W + 12;    // |b-a| << 12
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int H_W       = DIV_W + 1;       // signed step width
  localparam int X_W       = H_W;             // signed sample point
  localparam int X2_W      = 32;              // x^2, Q.24
  localparam int X3_W      = 36;              // x^3, Q.24, signed
  localparam int MUL_A_W   = 36;
  localparam int MUL_B_W   = 30;
  localparam int PROD_W    = 64;
  localparam int ACC_W     = 52;              // polynomial sum before the final >> 8
  localparam int P_W       = ACC_W - 8;
  localparam int LO_W      = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CUBIC    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SQUARE   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONSTANT = 4'd3;

  // Coefficient reset values, Q8.8
  localparam logic signed [COEFF_W-1:0] RST_CUBIC    = 16'sd256;
  localparam logic signed [COEFF_W-1:0] RST_SQUARE   = -16'sd768;
  localparam logic signed [COEFF_W-1:0] RST_LINEAR   = 16'sd0;
  localparam logic signed [COEFF_W-1:0] RST_CONSTANT = 16'sd512;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT  = 2'd2;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [BOUND_W-1:0] lower_bound;
    logic signed [BOUND_W-1:0] upper_bound;
    logic        [COUNT_W-1:0] step_count;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0]    integral;
    logic        [STATUS_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic signed [COEFF_W-1:0] c3;
    logic signed [COEFF_W-1:0] c2;
    logic signed [COEFF_W-1:0] c1;
    logic signed [COEFF_W-1:0] c0;
  } coeff_t;

  // Microcode
  localparam int UADDR_W = 4;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_XX, MUL_X2X, MUL_C2X2, MUL_C1X, MUL_C3X3, MUL_LO, MUL_HI
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_LOAD, ACC_ADD, ACC_ADD_PEND
  } acc_op_t;

  typedef enum logic [2:0] {
    COND_NEVER, COND_NO_START, COND_N_ZERO, COND_DIV_BUSY, COND_CNT_NZ, COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    mul_sel_t             mul;
    acc_op_t              acc;
    logic                 x2_ld;
    logic                 x3_ld;
    logic                 s_add;
    logic                 div_step;
    logic                 h_fix;
    logic                 x_next;
    logic                 mag_ld;
    logic                 q_lo;
    logic                 q_hi;
    logic                 out_wr;
    cond_t                cond;
    logic [UADDR_W-1:0]   target;
    logic                 ret;
  } ctl_t;

  typedef struct packed {
    logic div_busy;
    logic cnt_nz;
    logic n_zero;
    logic out_busy;
  } dp_stat_t;

  // Program addresses
  localparam logic [UADDR_W-1:0] U_WAIT = 4'd0;
  localparam logic [UADDR_W-1:0] U_CHKN = 4'd1;
  localparam logic [UADDR_W-1:0] U_DIV  = 4'd2;
  localparam logic [UADDR_W-1:0] U_HFIX = 4'd3;
  localparam logic [UADDR_W-1:0] U_L0   = 4'd4;
  localparam logic [UADDR_W-1:0] U_L1   = 4'd5;
  localparam logic [UADDR_W-1:0] U_L2   = 4'd6;
  localparam logic [UADDR_W-1:0] U_L3   = 4'd7;
  localparam logic [UADDR_W-1:0] U_L4   = 4'd8;
  localparam logic [UADDR_W-1:0] U_D0   = 4'd9;
  localparam logic [UADDR_W-1:0] U_D1   = 4'd10;
  localparam logic [UADDR_W-1:0] U_MAG  = 4'd11;
  localparam logic [UADDR_W-1:0] U_MLO  = 4'd12;
  localparam logic [UADDR_W-1:0] U_MHI  = 4'd13;
  localparam logic [UADDR_W-1:0] U_QSUM = 4'd14;
  localparam logic [UADDR_W-1:0] U_OUT  = 4'd15;

  // Control store. The sample loop L0..L4 keeps the multiplier busy every
  // cycle; the last accumulate of one sample overlaps the next one's start.
  function automatic ctl_t ucode(input logic [UADDR_W-1:0] addr);
    ctl_t c;
    c = '0;
    case (addr)
      U_WAIT: begin
        c.cond = COND_NO_START; c.target = U_WAIT;
      end
      U_CHKN: begin
        c.cond = COND_N_ZERO; c.target = U_OUT;
      end
      U_DIV: begin
        c.div_step = 1'b1; c.cond = COND_DIV_BUSY; c.target = U_DIV;
      end
      U_HFIX: begin
        c.h_fix = 1'b1;
      end
      U_L0: begin
        c.mul = MUL_XX; c.acc = ACC_ADD_PEND;
      end
      U_L1: begin
        c.mul = MUL_X2X; c.x2_ld = 1'b1; c.s_add = 1'b1;
      end
      U_L2: begin
        c.mul = MUL_C2X2; c.x3_ld = 1'b1;
      end
      U_L3: begin
        c.mul = MUL_C1X; c.acc = ACC_LOAD;
      end
      U_L4: begin
        c.mul = MUL_C3X3; c.acc = ACC_ADD; c.x_next = 1'b1;
        c.cond = COND_CNT_NZ; c.target = U_L0;
      end
      U_D0: begin
        c.acc = ACC_ADD;
      end
      U_D1: begin
        c.s_add = 1'b1;
      end
      U_MAG: begin
        c.mag_ld = 1'b1;
      end
      U_MLO: begin
        c.mul = MUL_LO;
      end
      U_MHI: begin
        c.mul = MUL_HI; c.q_lo = 1'b1;
      end
      U_QSUM: begin
        c.q_hi = 1'b1;
      end
      U_OUT: begin
        c.out_wr = 1'b1; c.cond = COND_OUT_BUSY; c.target = U_OUT; c.ret = 1'b1;
      end
      default: begin
        c.ret = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/tic_sequencer.sv =====
module tic_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  tic_pkg::dp_stat_t   stat,
  output tic_pkg::ctl_t       ctl,
  output logic                at_wait
);

  logic [tic_pkg::UADDR_W-1:0] pc_r;
  logic [tic_pkg::UADDR_W-1:0] pc_nxt;
  logic                        cond_hit;

  assign ctl     = tic_pkg::ucode(pc_r);
  assign at_wait = (pc_r == tic_pkg::U_WAIT);

  // branch condition select
  always_comb begin
    case (ctl.cond)
      tic_pkg::COND_NO_START: cond_hit = !start;
      tic_pkg::COND_N_ZERO:   cond_hit = stat.n_zero;
      tic_pkg::COND_DIV_BUSY: cond_hit = stat.div_busy;
      tic_pkg::COND_CNT_NZ:   cond_hit = stat.cnt_nz;
      tic_pkg::COND_OUT_BUSY: cond_hit = stat.out_busy;
      default:                cond_hit = 1'b0;
    endcase
  end

  // next address: jump, return to wait, or fall through
  always_comb begin
    if (cond_hit) begin
      pc_nxt = ctl.target;
    end else if (ctl.ret) begin
      pc_nxt = tic_pkg::U_WAIT;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= tic_pkg::U_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== rtl/tic_datapath.sv =====
module tic_datapath #(
  parameter int STEP_BITS = tic_pkg::STEP_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  tic_pkg::in_item_t   in_data,
  input  tic_pkg::coeff_t     coeff,
  input  tic_pkg::ctl_t       ctl,
  input  logic                out_stall,
  output logic                out_valid,
  output tic_pkg::out_item_t  out_data,
  output tic_pkg::dp_stat_t   stat
);

  localparam int N_W  = (STEP_BITS < tic_pkg::COUNT_W) ? STEP_BITS : tic_pkg::COUNT_W;
  localparam int S_W  = tic_pkg::P_W + N_W + 2;
  localparam int Q_W  = S_W + 3;
  localparam int HI_W = S_W - tic_pkg::LO_W;
  localparam int MH_W = tic_pkg::DIV_W;
  localparam logic [tic_pkg::DIV_CNT_W-1:0] DIV_LAST = tic_pkg::DIV_CNT_W'(tic_pkg::DIV_W - 1);

  // operands
  logic signed [tic_pkg::BOUND_W-1:0] a_r, b_r;
  logic        [N_W-1:0]              n_r, cnt_r;
  logic signed [tic_pkg::X_W-1:0]     a24, b24;

  // division
  logic        [tic_pkg::DIV_W-1:0]     dq_r;
  logic        [N_W:0]                  rem_r, rem_sh;
  logic        [tic_pkg::DIV_CNT_W-1:0] dcnt_r;
  logic                                 sign_r;
  logic signed [tic_pkg::BOUND_W:0]     diff;
  logic        [tic_pkg::BOUND_W:0]     diff_abs;
  logic                                 q_bit;

  // sample evaluation
  logic signed [tic_pkg::H_W-1:0]     h_r;
  logic signed [tic_pkg::X_W-1:0]     x_r;
  logic signed [tic_pkg::X2_W-1:0]    x2_r, x2_new;
  logic signed [tic_pkg::X3_W-1:0]    x3_r, x3_new;
  logic signed [tic_pkg::MUL_A_W-1:0] op_a;
  logic signed [tic_pkg::MUL_B_W-1:0] op_b;
  logic signed [tic_pkg::MUL_A_W+tic_pkg::MUL_B_W-1:0] prod_full;
  logic signed [tic_pkg::PROD_W-1:0]  prod_r;
  logic signed [tic_pkg::ACC_W-1:0]   acc_r, acc_nxt, c0_sh;
  logic signed [tic_pkg::P_W-1:0]     p_val;
  logic signed [S_W-1:0]              s_r, s_nxt, p_ext;
  logic                               wx_r, wacc_r, pend_r;

  // final scaling
  logic [S_W-1:0]  ma_r;
  logic [MH_W-1:0] mh_r;
  logic            neg_r;
  logic [Q_W-1:0]  q_r;

  // result
  logic                 out_valid_r;
  tic_pkg::out_item_t   out_data_r, res;
  logic                 out_busy, out_we;

  assign a24 = tic_pkg::X_W'($signed({a_r, 12'd0}));
  assign b24 = tic_pkg::X_W'($signed({b_r, 12'd0}));

  // |b - a| << 12 and its sign for the step width division
  assign diff     = $signed({in_data.upper_bound[tic_pkg::BOUND_W-1], in_data.upper_bound})
                  - $signed({in_data.lower_bound[tic_pkg::BOUND_W-1], in_data.lower_bound});
  assign diff_abs = diff[tic_pkg::BOUND_W] ? (~diff + 1'b1) : diff;

  // restoring divide step
  assign rem_sh = {rem_r[N_W-1:0], dq_r[tic_pkg::DIV_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, n_r});

  assign x2_new = prod_r[tic_pkg::FRAC +: tic_pkg::X2_W];
  assign x3_new = prod_r[tic_pkg::FRAC +: tic_pkg::X3_W];

  // shared multiplier operand select
  always_comb begin
    case (ctl.mul)
      tic_pkg::MUL_XX: begin
        op_a = tic_pkg::MUL_A_W'(x_r);   op_b = tic_pkg::MUL_B_W'(x_r);
      end
      tic_pkg::MUL_X2X: begin
        op_a = tic_pkg::MUL_A_W'(x2_new); op_b = tic_pkg::MUL_B_W'(x_r);
      end
      tic_pkg::MUL_C2X2: begin
        op_a = tic_pkg::MUL_A_W'(x2_r);  op_b = tic_pkg::MUL_B_W'(coeff.c2);
      end
      tic_pkg::MUL_C1X: begin
        op_a = tic_pkg::MUL_A_W'(x_r);   op_b = tic_pkg::MUL_B_W'(coeff.c1);
      end
      tic_pkg::MUL_C3X3: begin
        op_a = tic_pkg::MUL_A_W'(x3_r);  op_b = tic_pkg::MUL_B_W'(coeff.c3);
      end
      tic_pkg::MUL_LO: begin
        op_a = tic_pkg::MUL_A_W'({1'b0, ma_r[tic_pkg::LO_W-1:0]});
        op_b = tic_pkg::MUL_B_W'({1'b0, mh_r});
      end
      tic_pkg::MUL_HI: begin
        op_a = tic_pkg::MUL_A_W'({1'b0, ma_r[S_W-1:tic_pkg::LO_W]});
        op_b = tic_pkg::MUL_B_W'({1'b0, mh_r});
      end
      default: begin
        op_a = '0; op_b = '0;
      end
    endcase
  end

  assign prod_full = op_a * op_b;

  // polynomial accumulator
  assign c0_sh = tic_pkg::ACC_W'(coeff.c0) <<< tic_pkg::FRAC;

  always_comb begin
    case (ctl.acc)
      tic_pkg::ACC_LOAD:     acc_nxt = c0_sh + tic_pkg::ACC_W'(prod_r);
      tic_pkg::ACC_ADD:      acc_nxt = acc_r + tic_pkg::ACC_W'(prod_r);
      tic_pkg::ACC_ADD_PEND: acc_nxt = pend_r ? (acc_r + tic_pkg::ACC_W'(prod_r)) : acc_r;
      default:               acc_nxt = acc_r;
    endcase
  end

  // weighted sum: endpoints once, interior samples twice
  assign p_val = acc_r[tic_pkg::ACC_W-1:8];
  assign p_ext = S_W'(p_val);
  assign s_nxt = s_r + (wacc_r ? (p_ext <<< 1) : p_ext);

  // zero-count status, saturation and sign of the scaled result
  always_comb begin
    res = '0;
    if (n_r == '0) begin
      res.integral = '0;
      res.status   = tic_pkg::ST_ZERO;
    end else if (!neg_r) begin
      if (q_r > Q_W'(tic_pkg::OUT_MAX)) begin
        res.integral = tic_pkg::OUT_MAX;
        res.status   = tic_pkg::ST_SAT;
      end else begin
        res.integral = q_r[tic_pkg::OUT_W-1:0];
        res.status   = tic_pkg::ST_OK;
      end
    end else begin
      if (q_r > Q_W'({1'b1, {(tic_pkg::OUT_W-1){1'b0}}})) begin
        res.integral = tic_pkg::OUT_MIN;
        res.status   = tic_pkg::ST_SAT;
      end else begin
        res.integral = -q_r[tic_pkg::OUT_W-1:0];
        res.status   = tic_pkg::ST_OK;
      end
    end
  end

  assign out_busy = out_valid_r && out_stall;
  assign out_we   = ctl.out_wr && !out_busy;

  assign stat.div_busy = (dcnt_r != '0);
  assign stat.cnt_nz   = (cnt_r != '0);
  assign stat.n_zero   = (n_r == '0);
  assign stat.out_busy = out_busy;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (out_we) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        pend_r <= 1'b0;
      end else if (ctl.acc == tic_pkg::ACC_LOAD) begin
        pend_r <= 1'b1;
      end else if (ctl.s_add) begin
        pend_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= prod_full[tic_pkg::PROD_W-1:0];
    acc_r  <= acc_nxt;
    if (out_we) begin
      out_data_r <= res;
    end

    if (load) begin
      a_r    <= in_data.lower_bound;
      b_r    <= in_data.upper_bound;
      n_r    <= in_data.step_count[N_W-1:0];
      dq_r   <= {diff_abs[tic_pkg::BOUND_W-1:0], 12'd0};
      rem_r  <= '0;
      dcnt_r <= DIV_LAST;
      sign_r <= diff[tic_pkg::BOUND_W];
      s_r    <= '0;
    end else begin
      if (ctl.div_step) begin
        rem_r <= q_bit ? (rem_sh - {1'b0, n_r}) : rem_sh;
        dq_r  <= {dq_r[tic_pkg::DIV_W-2:0], q_bit};
        if (dcnt_r != '0) begin
          dcnt_r <= dcnt_r - 1'b1;
        end
      end
      if (ctl.s_add && pend_r) begin
        s_r <= s_nxt;
      end
    end

    // step width and first sample point, then the advance to each next sample point
    if (ctl.h_fix) begin
      h_r   <= sign_r ? -tic_pkg::H_W'({1'b0, dq_r}) : tic_pkg::H_W'({1'b0, dq_r});
      x_r   <= a24;
      wx_r  <= 1'b0;
      cnt_r <= n_r;
    end else if (ctl.x_next) begin
      if (cnt_r == N_W'(1)) begin
        x_r  <= b24;
        wx_r <= 1'b0;
      end else begin
        x_r  <= x_r + h_r;
        wx_r <= 1'b1;
      end
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end

    if (ctl.x2_ld) begin
      x2_r <= x2_new;
    end
    if (ctl.x3_ld) begin
      x3_r <= x3_new;
    end
    if (ctl.acc == tic_pkg::ACC_LOAD) begin
      wacc_r <= wx_r;
    end

    // magnitudes for the final h * S / 2^25
    if (ctl.mag_ld) begin
      ma_r  <= s_r[S_W-1] ? S_W'(-s_r) : S_W'(s_r);
      mh_r  <= h_r[tic_pkg::H_W-1] ? MH_W'(-h_r) : MH_W'(h_r);
      neg_r <= s_r[S_W-1] ^ h_r[tic_pkg::H_W-1];
    end
    if (ctl.q_lo) begin
      q_r <= Q_W'(prod_r[tic_pkg::PROD_W-1:25]);
    end else if (ctl.q_hi) begin
      q_r <= q_r + {prod_r[Q_W-8:0], 7'd0};
    end
  end

endmodule

// ===== rtl/trapezoid_integrate_cubic.sv =====
// Items are not overlapped: in_stall stays high until the sequencer is back in wait,
//   so a new item is taken only after the last result has been written. The shared
//   36x30 multiplier runs five products per sample point, plus a bit-serial divide
//   for the step width.
// Reset (rst_n low, synchronous): sequencer returns to wait, result register empties,
//   coefficients reload to x^3 - 3x^2 + 2.
module trapezoid_integrate_cubic #(
  parameter int STEP_BITS = tic_pkg::STEP_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tic_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tic_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tic_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tic_pkg::COEFF_W-1:0]     cfg_data
);

  tic_pkg::coeff_t    coeff_r;
  tic_pkg::ctl_t      ctl;
  tic_pkg::dp_stat_t  stat;
  logic               at_wait;
  logic               load;

  assign in_stall  = !at_wait;
  assign load      = in_valid && at_wait;
  assign cfg_ready = 1'b1;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r.c3 <= tic_pkg::RST_CUBIC;
      coeff_r.c2 <= tic_pkg::RST_SQUARE;
      coeff_r.c1 <= tic_pkg::RST_LINEAR;
      coeff_r.c0 <= tic_pkg::RST_CONSTANT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tic_pkg::REG_CUBIC:    coeff_r.c3 <= cfg_data;
        tic_pkg::REG_SQUARE:   coeff_r.c2 <= cfg_data;
        tic_pkg::REG_LINEAR:   coeff_r.c1 <= cfg_data;
        tic_pkg::REG_CONSTANT: coeff_r.c0 <= cfg_data;
        default: ;
      endcase
    end
  end

  tic_sequencer u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_valid),
    .stat    (stat),
    .ctl     (ctl),
    .at_wait (at_wait)
  );

  tic_datapath #(
    .STEP_BITS (STEP_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .in_data   (in_data),
    .coeff     (coeff_r),
    .ctl       (ctl),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

  // zero step count always carries a zero integral
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == tic_pkg::ST_ZERO |-> out_data.integral == '0)
    else $error("zero step count result with nonzero integral");

  // saturation flag only with a rail value
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == tic_pkg::ST_SAT |->
      (out_data.integral == tic_pkg::OUT_MAX || out_data.integral == tic_pkg::OUT_MIN))
    else $error("saturated result not at a rail");

  // status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == tic_pkg::ST_OK || out_data.status == tic_pkg::ST_ZERO ||
                   out_data.status == tic_pkg::ST_SAT))
    else $error("undefined status code");

  // an input transfer always sends the sequencer out of wait
  a_leave_wait: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("sequencer stayed in wait after an input transfer");

endmodule

// ===== tb/tb_trapezoid_integrate_cubic.sv =====
`timescale 1ns / 100ps

module tb_trapezoid_integrate_cubic;

  localparam int STEP_BITS   = tic_pkg::STEP_BITS_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 16;
  localparam int SETTLE      = 100;

  // Indexes outside the register file; writes to them are dropped
  localparam logic [tic_pkg::CFG_IDX_W-1:0] REG_NONE_LO = 4'd4;
  localparam logic [tic_pkg::CFG_IDX_W-1:0] REG_NONE_HI = 4'd15;

  localparam logic signed [tic_pkg::BOUND_W-1:0] ONE_Q12   = 16'sd4096;
  localparam logic signed [tic_pkg::BOUND_W-1:0] TWO_Q12   = 16'sd8192;
  localparam logic signed [tic_pkg::BOUND_W-1:0] BOUND_MIN = -16'sd32768;
  localparam logic signed [tic_pkg::BOUND_W-1:0] BOUND_MAX = 16'sd32767;
  localparam logic signed [tic_pkg::OUT_W-1:0]   ONE_Q24   = 48'sh00_0001_000000;
  localparam logic [tic_pkg::COEFF_W-1:0]        COEFF_MAX = 16'h7FFF;
  localparam logic [tic_pkg::COEFF_W-1:0]        COEFF_MIN = 16'h8000;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_KNOWN, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                     kind;
    tic_pkg::in_item_t             item;
    tic_pkg::out_item_t            known;
    logic [tic_pkg::CFG_IDX_W-1:0] idx;
    logic [tic_pkg::COEFF_W-1:0]   value;
  } row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  tic_pkg::in_item_t             in_data;
  logic                          out_valid;
  logic                          out_stall;
  tic_pkg::out_item_t            out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [tic_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tic_pkg::COEFF_W-1:0]   cfg_data;

  tic_pkg::coeff_t    coeffs;             // our copy of the coefficient registers
  tic_pkg::out_item_t pending_results[$]; // integrals still to come back, oldest first
  row_t               directed_rows[$];
  int                 errors;
  bit                 no_idle;            // both sides run without gaps
  bit                 hold_request;       // receiver to hold off for a long stretch

  trapezoid_integrate_cubic #(.STEP_BITS(STEP_BITS)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The timeout leaves about four times the worst correct run (one 65535-step item
  // plus ~110 items of up to 255 steps).
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------

  // Cubic at x (Q.24), floor rounding after x^2, after x^3 and after the final >> 8
  function automatic longint cubic_at(input longint x, input tic_pkg::coeff_t c);
    longint sq, cb, acc;
    sq  = (x * x) >>> tic_pkg::FRAC;
    cb  = (sq * x) >>> tic_pkg::FRAC;
    acc = longint'(c.c3) * cb + longint'(c.c2) * sq + longint'(c.c1) * x
        + (longint'(c.c0) <<< tic_pkg::FRAC);
    return acc >>> 8;
  endfunction

  function automatic tic_pkg::out_item_t trapezoid_sum(input tic_pkg::in_item_t item,
                                                       input tic_pkg::coeff_t c);
    tic_pkg::out_item_t r;
    longint             n, a24, b24, h, s, i;
    logic [63:0]        ms, mh, q;
    logic [127:0]       prod;
    bit                 neg;
    r.integral = '0;
    r.status   = tic_pkg::ST_OK;
    n = longint'(item.step_count) & ((longint'(1) << STEP_BITS) - 1);
    if (n == 0) begin
      r.status = tic_pkg::ST_ZERO;
      return r;
    end
    a24 = longint'(item.lower_bound) <<< 12;
    b24 = longint'(item.upper_bound) <<< 12;
    h   = (b24 - a24) / n;  // truncates toward zero
    s   = cubic_at(a24, c) + cubic_at(b24, c);
    for (i = 1; i < n; i++)
      s += 2 * cubic_at(a24 + i * h, c);
    // |S| * |h| / 2^25, sign applied afterwards
    neg  = (s < 0) != (h < 0);
    ms   = (s < 0) ? -s : s;
    mh   = (h < 0) ? -h : h;
    prod = ms * mh;
    q    = 64'(prod >> 25);
    if (!neg && q > (64'd1 << (tic_pkg::OUT_W - 1)) - 64'd1) begin
      r.integral = tic_pkg::OUT_MAX;
      r.status   = tic_pkg::ST_SAT;
    end else if (neg && q > (64'd1 << (tic_pkg::OUT_W - 1))) begin
      r.integral = tic_pkg::OUT_MIN;
      r.status   = tic_pkg::ST_SAT;
    end else begin
      r.integral = neg ? -q[tic_pkg::OUT_W-1:0] : q[tic_pkg::OUT_W-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    tic_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result integral %h status %0d",
                                  out_data.integral, out_data.status));
      end else begin
        want = pending_results.pop_front();
        if (out_data.integral !== want.integral)
          report_mismatch($sformatf("integral %h, expected %h",
                                    out_data.integral, want.integral));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_data.status, want.status));
      end
    end
  end

  // Receiver: random stall before each transfer, one long hold-off on request
  initial begin
    int stall_cycles;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        stall_cycles = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall_cycles = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------

  // Entered and left at a falling edge; in_valid stays high when the next
  // item follows without a gap.
  task automatic send_item(input tic_pkg::in_item_t item, input bit known,
                           input tic_pkg::out_item_t known_res);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(known ? known_res : trapezoid_sum(item, coeffs));
    @(negedge clk);
  endtask

  // Stop offering items and wait for every outstanding integral
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_coeff(input logic [tic_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tic_pkg::COEFF_W-1:0] value);
    drain_results();
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tic_pkg::REG_CUBIC:    coeffs.c3 = value;
      tic_pkg::REG_SQUARE:   coeffs.c2 = value;
      tic_pkg::REG_LINEAR:   coeffs.c1 = value;
      tic_pkg::REG_CONSTANT: coeffs.c0 = value;
      default: ;    // outside the register file: dropped
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void add_item(input row_kind_t kind, input logic [15:0] a,
                                   input logic [15:0] b, input logic [15:0] n,
                                   input logic [tic_pkg::OUT_W-1:0] integral,
                                   input logic [tic_pkg::STATUS_W-1:0] status);
    row_t r;
    r       = '0;
    r.kind  = kind;
    r.item  = '{lower_bound: a, upper_bound: b, step_count: n};
    r.known = '{integral: integral, status: status};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_write(input logic [tic_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [tic_pkg::COEFF_W-1:0] value);
    row_t r;
    r       = '0;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.value = value;
    directed_rows.push_back(r);
  endfunction

  function automatic logic [tic_pkg::COEFF_W-1:0] pick_coeff();
    case ($urandom_range(0, 4))
      0:       return COEFF_MAX;
      1:       return COEFF_MIN;
      2:       return '0;
      3:       return 16'($urandom_range(0, 1024)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly short step counts; wide spans, near spans and reversed bounds
  function automatic tic_pkg::in_item_t random_item(input bit short_only);
    tic_pkg::in_item_t it;
    int                pick;
    it.lower_bound = 16'($urandom);
    if ($urandom_range(0, 99) < 30)
      it.upper_bound = it.lower_bound + 16'($urandom_range(0, 2048)) - 16'd1024;
    else
      it.upper_bound = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (short_only)     it.step_count = 16'($urandom_range(1, 3));
    else if (pick < 5)  it.step_count = '0;
    else if (pick < 85) it.step_count = 16'($urandom_range(1, 12));
    else                it.step_count = 16'($urandom_range(13, 255));
    return it;
  endfunction

  initial begin
    int ph, k;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    errors       = 0;
    no_idle      = 1'b0;
    hold_request = 1'b0;
    coeffs       = '{c3: tic_pkg::RST_CUBIC, c2: tic_pkg::RST_SQUARE,
                     c1: tic_pkg::RST_LINEAR, c0: tic_pkg::RST_CONSTANT};
    rst_n        = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset coefficients first
    add_item(ROW_KNOWN, '0, ONE_Q12, '0, '0, tic_pkg::ST_ZERO);
    add_item(ROW_KNOWN, BOUND_MIN, BOUND_MAX, '0, '0, tic_pkg::ST_ZERO);
    add_item(ROW_KNOWN, ONE_Q12, ONE_Q12, 16'd5, '0, tic_pkg::ST_OK);
    add_item(ROW_PREDICT, '0, TWO_Q12, 16'd1, '0, tic_pkg::ST_OK);
    add_item(ROW_PREDICT, '0, TWO_Q12, 16'd16, '0, tic_pkg::ST_OK);
    add_item(ROW_PREDICT, BOUND_MIN, BOUND_MAX, 16'd1, '0, tic_pkg::ST_OK);
    add_item(ROW_PREDICT, BOUND_MIN, BOUND_MAX, 16'd100, '0, tic_pkg::ST_OK);
    add_item(ROW_PREDICT, BOUND_MAX, BOUND_MIN, 16'd7, '0, tic_pkg::ST_OK);
    add_item(ROW_PREDICT, ONE_Q12, '0, 16'd3, '0, tic_pkg::ST_OK);
    add_item(ROW_PREDICT, '0, ONE_Q12, 16'hFFFF, '0, tic_pkg::ST_OK);
    // p(x) = 1.0: the integral is the span
    add_write(tic_pkg::REG_CUBIC, '0);
    add_write(tic_pkg::REG_SQUARE, '0);
    add_write(tic_pkg::REG_LINEAR, '0);
    add_write(tic_pkg::REG_CONSTANT, 16'd256);
    add_item(ROW_KNOWN, '0, ONE_Q12, 16'd1, ONE_Q24, tic_pkg::ST_OK);
    add_item(ROW_KNOWN, '0, ONE_Q12, 16'd4, ONE_Q24, tic_pkg::ST_OK);
    add_item(ROW_KNOWN, ONE_Q12, '0, 16'd1, -ONE_Q24, tic_pkg::ST_OK);
    add_write(REG_NONE_LO, COEFF_MIN);
    add_write(REG_NONE_HI, COEFF_MAX);
    add_item(ROW_KNOWN, '0, ONE_Q12, 16'd2, ONE_Q24, tic_pkg::ST_OK);
    // coefficient extremes
    add_write(tic_pkg::REG_CUBIC, COEFF_MAX);
    add_write(tic_pkg::REG_SQUARE, COEFF_MAX);
    add_write(tic_pkg::REG_LINEAR, COEFF_MAX);
    add_write(tic_pkg::REG_CONSTANT, COEFF_MAX);
    add_item(ROW_PREDICT, BOUND_MIN, BOUND_MAX, 16'd1, '0, tic_pkg::ST_OK);
    add_item(ROW_PREDICT, BOUND_MIN, BOUND_MAX, 16'd50, '0, tic_pkg::ST_OK);
    add_item(ROW_PREDICT, BOUND_MAX, BOUND_MAX, 16'd9, '0, tic_pkg::ST_OK);
    add_write(tic_pkg::REG_CUBIC, COEFF_MIN);
    add_write(tic_pkg::REG_SQUARE, COEFF_MIN);
    add_write(tic_pkg::REG_LINEAR, COEFF_MIN);
    add_write(tic_pkg::REG_CONSTANT, COEFF_MIN);
    add_item(ROW_PREDICT, BOUND_MIN, BOUND_MAX, 16'd3, '0, tic_pkg::ST_OK);
    add_item(ROW_PREDICT, BOUND_MAX, BOUND_MIN, 16'd1, '0, tic_pkg::ST_OK);
    add_item(ROW_PREDICT, BOUND_MIN, '0, 16'd12, '0, tic_pkg::ST_OK);

    foreach (directed_rows[j]) begin
      case (directed_rows[j].kind)
        ROW_WRITE: write_coeff(directed_rows[j].idx, directed_rows[j].value);
        ROW_KNOWN: send_item(directed_rows[j].item, 1'b1, directed_rows[j].known);
        default:   send_item(directed_rows[j].item, 1'b0, '0);
      endcase
    end

    // Random phases, fresh coefficients each time
    for (ph = 0; ph < PHASES; ph++) begin
      write_coeff(tic_pkg::REG_CUBIC, pick_coeff());
      write_coeff(tic_pkg::REG_SQUARE, pick_coeff());
      write_coeff(tic_pkg::REG_LINEAR, pick_coeff());
      write_coeff(tic_pkg::REG_CONSTANT, pick_coeff());
      no_idle = (ph == 2);
      // one phase of short items against a receiver that stops taking results
      if (ph == 4) hold_request = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++)
        send_item(random_item(ph == 4), 1'b0, '0);
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== trapezoid_integrate_cubic.f =====
rtl/tic_pkg.sv
rtl/tic_sequencer.sv
rtl/tic_datapath.sv
rtl/trapezoid_integrate_cubic.sv
tb/tb_trapezoid_integrate_cubic.sv
